// File: src/gsp_pkg.sv
// Shared types and constants for the gain scheduled PID step block.
package gsp_pkg;

    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 12;
    localparam int DRIVE_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_BITS  = 24;
    localparam int QSAT_W     = 21;
    localparam int QSAT       = 1 << 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_GAIN        = 3'd0,
        REG_I_GAIN        = 3'd1,
        REG_D_GAIN        = 3'd2,
        REG_DEAD_ZONE     = 3'd3,
        REG_INTEGRAL_BAND = 3'd4,
        REG_OUT_MAX       = 3'd5,
        REG_OUT_MIN       = 3'd6
    } gsp_reg_idx_t;

    localparam logic [GAIN_W-1:0]         P_GAIN_RST    = 32'd838860800;
    localparam logic [GAIN_W-1:0]         I_GAIN_RST    = 32'd168;
    localparam logic [GAIN_W-1:0]         D_GAIN_RST    = 32'd1677722;
    localparam logic [LIM_W-1:0]          DEAD_ZONE_RST = 12'd3;
    localparam logic [LIM_W-1:0]          BAND_RST      = 12'd55;
    localparam logic signed [DRIVE_W-1:0] OUT_MAX_RST   = 16'sd20000;
    localparam logic signed [DRIVE_W-1:0] OUT_MIN_RST   = -16'sd20000;

    typedef struct packed {
        logic [GAIN_W-1:0]  p_gain;
        logic [GAIN_W-1:0]  i_gain;
        logic [GAIN_W-1:0]  d_gain;
        logic [LIM_W-1:0]   dead_zone;
        logic [LIM_W-1:0]   integral_band;
        logic [DRIVE_W-1:0] out_max;
        logic [DRIVE_W-1:0] out_min;
    } gsp_cfg_t;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
        logic ld_d;
        logic ld_o;
    } gsp_ctrl_t;

endpackage

// File: src/gain_scheduled_pid_step.sv
// Top level of the gain scheduled PID step: handshake, registers and stage wiring.
//
// Discrete PID position controller with a dead zone and integral separation. Each input
// word carries a target and a measured position; each yields exactly one output word with
// the clamped drive and a dead zone flag. The error is always added into a saturating
// running sum and the previous error is kept for the derivative term. A new word is taken
// every cycle while the output is not stalled; results pass through five register stages
// (input, error/state, multiplies, term sum, clamp). The state update sits
// in one stage so consecutive words see each other's sum without a stall. Each stage has
// its own valid bit, so the block keeps accepting while a result waits and bubbles close
// up. Gains are unsigned Q8.24; the I gain is applied twice. Registers are to be written
// only while the block is idle; the block itself does not enforce this.
module gain_scheduled_pid_step
    import gsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_BITS    = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // target, measured, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drive
    output logic [DRIVE_W-1:0]                m_axis_tdata,
    // in_dead_zone
    output logic [0:0]                        m_axis_tuser
);

    localparam int LO = SUM_BITS / 2;

    gsp_cfg_t  cfg_reg;
    gsp_ctrl_t ctrl;

    logic v_a_reg;
    logic v_b_reg;
    logic v_c_reg;
    logic v_d_reg;
    logic v_o_reg;
    logic rdy_a;
    logic rdy_b;
    logic rdy_c;
    logic rdy_d;
    logic rdy_o;

    logic signed [SAMPLE_BITS:0]             err_b;
    logic signed [SAMPLE_BITS+1:0]           diff_b;
    logic signed [SUM_BITS-1:0]              sum_b;
    logic                                    use_pd_b;
    logic                                    use_i_b;
    logic                                    dead_b;
    logic signed [GAIN_W+SAMPLE_BITS+1:0]    pp_c;
    logic signed [GAIN_W+SAMPLE_BITS+2:0]    dp_c;
    logic signed [GAIN_W+LO+1:0]             ilo_c;
    logic signed [GAIN_W+SUM_BITS-LO:0]      ihi_c;
    logic                                    dead_c;
    logic [DRIVE_W-1:0]                      drive_o;
    logic                                    dead_o;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p_gain        <= P_GAIN_RST;
            cfg_reg.i_gain        <= I_GAIN_RST;
            cfg_reg.d_gain        <= D_GAIN_RST;
            cfg_reg.dead_zone     <= DEAD_ZONE_RST;
            cfg_reg.integral_band <= BAND_RST;
            cfg_reg.out_max       <= OUT_MAX_RST;
            cfg_reg.out_min       <= OUT_MIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (gsp_reg_idx_t'(cfg_index))
                REG_P_GAIN:        cfg_reg.p_gain        <= cfg_data[GAIN_W-1:0];
                REG_I_GAIN:        cfg_reg.i_gain        <= cfg_data[GAIN_W-1:0];
                REG_D_GAIN:        cfg_reg.d_gain        <= cfg_data[GAIN_W-1:0];
                REG_DEAD_ZONE:     cfg_reg.dead_zone     <= cfg_data[LIM_W-1:0];
                REG_INTEGRAL_BAND: cfg_reg.integral_band <= cfg_data[LIM_W-1:0];
                REG_OUT_MAX:       cfg_reg.out_max       <= cfg_data[DRIVE_W-1:0];
                REG_OUT_MIN:       cfg_reg.out_min       <= cfg_data[DRIVE_W-1:0];
                default:           ;
            endcase
        end
    end

    // per-stage flow control
    always_comb
    begin
        rdy_o = !v_o_reg || m_axis_tready;
        rdy_d = !v_d_reg || rdy_o;
        rdy_c = !v_c_reg || rdy_d;
        rdy_b = !v_b_reg || rdy_c;
        rdy_a = !v_a_reg || rdy_b;

        ctrl.ld_a = rdy_a && s_axis_tvalid;
        ctrl.ld_b = rdy_b && v_a_reg;
        ctrl.ld_c = rdy_c && v_b_reg;
        ctrl.ld_d = rdy_d && v_c_reg;
        ctrl.ld_o = rdy_o && v_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
            v_o_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                v_a_reg <= s_axis_tvalid;
            if (rdy_b)
                v_b_reg <= v_a_reg;
            if (rdy_c)
                v_c_reg <= v_b_reg;
            if (rdy_d)
                v_d_reg <= v_c_reg;
            if (rdy_o)
                v_o_reg <= v_d_reg;
        end
    end

    gsp_err #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ctrl     (ctrl),
        .target   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .measured (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .err_b    (err_b),
        .diff_b   (diff_b),
        .sum_b    (sum_b),
        .use_pd_b (use_pd_b),
        .use_i_b  (use_i_b),
        .dead_b   (dead_b)
    );

    gsp_mult #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_mult (
        .clk      (clk),
        .cfg      (cfg_reg),
        .ctrl     (ctrl),
        .err_b    (err_b),
        .diff_b   (diff_b),
        .sum_b    (sum_b),
        .use_pd_b (use_pd_b),
        .use_i_b  (use_i_b),
        .dead_b   (dead_b),
        .pp_c     (pp_c),
        .dp_c     (dp_c),
        .ilo_c    (ilo_c),
        .ihi_c    (ihi_c),
        .dead_c   (dead_c)
    );

    gsp_sat #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_sat (
        .clk     (clk),
        .cfg     (cfg_reg),
        .ctrl    (ctrl),
        .pp_c    (pp_c),
        .dp_c    (dp_c),
        .ilo_c   (ilo_c),
        .ihi_c   (ihi_c),
        .dead_c  (dead_c),
        .drive_o (drive_o),
        .dead_o  (dead_o)
    );

    assign s_axis_tready   = rdy_a;
    assign m_axis_tvalid   = v_o_reg;
    assign m_axis_tdata    = drive_o;
    assign m_axis_tuser[0] = dead_o;

endmodule

// File: src/gsp_err.sv
// Input register, error/difference forming, saturating sum and gain selection.
module gsp_err
    import gsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_BITS    = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gsp_cfg_t                      cfg,
    input  gsp_ctrl_t                     ctrl,
    input  logic [SAMPLE_BITS-1:0]        target,
    input  logic [SAMPLE_BITS-1:0]        measured,
    output logic signed [SAMPLE_BITS:0]   err_b,
    output logic signed [SAMPLE_BITS+1:0] diff_b,
    output logic signed [SUM_BITS-1:0]    sum_b,
    output logic                          use_pd_b,
    output logic                          use_i_b,
    output logic                          dead_b
);

    localparam int EW = SAMPLE_BITS + 1;
    localparam int DW = SAMPLE_BITS + 2;
    localparam int CW = (SAMPLE_BITS > LIM_W) ? SAMPLE_BITS : LIM_W;
    localparam int SW = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;

    logic [SAMPLE_BITS-1:0]     target_reg;
    logic [SAMPLE_BITS-1:0]     measured_reg;
    logic signed [SUM_BITS-1:0] error_sum_reg;
    logic signed [SUM_BITS-1:0] error_sum_next;
    logic signed [EW-1:0]       prev_error_reg;

    logic signed [EW-1:0]  err;
    logic signed [EW-1:0]  neg_err;
    logic signed [DW-1:0]  diff;
    logic [SAMPLE_BITS-1:0] mag;
    logic [CW-1:0]         mag_w;
    logic signed [SW-1:0]  sum_wide;
    logic signed [SW-1:0]  smax_w;
    logic signed [SW-1:0]  smin_w;
    logic                  dead;
    logic                  in_band;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_a)
        begin
            target_reg   <= target;
            measured_reg <= measured;
        end
    end

    always_comb
    begin
        err     = $signed({1'b0, target_reg}) - $signed({1'b0, measured_reg});
        neg_err = -err;
        diff    = DW'(err) - DW'(prev_error_reg);
        mag     = err[EW-1] ? neg_err[SAMPLE_BITS-1:0] : err[SAMPLE_BITS-1:0];
        mag_w   = CW'(mag);
        dead    = mag_w < CW'(cfg.dead_zone);
        in_band = mag_w <= CW'(cfg.integral_band);
    end

    always_comb
    begin
        smax_w   = SW'({1'b0, {(SUM_BITS-1){1'b1}}});
        smin_w   = ~smax_w;
        sum_wide = SW'(error_sum_reg) + SW'(err);
        priority if (sum_wide > smax_w)
            error_sum_next = smax_w[SUM_BITS-1:0];
        else if (sum_wide < smin_w)
            error_sum_next = smin_w[SUM_BITS-1:0];
        else
            error_sum_next = sum_wide[SUM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end
        else if (ctrl.ld_b)
        begin
            error_sum_reg  <= error_sum_next;
            prev_error_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_b)
        begin
            err_b    <= err;
            diff_b   <= diff;
            sum_b    <= error_sum_next;
            use_pd_b <= !dead;
            use_i_b  <= !dead && in_band;
            dead_b   <= dead;
        end
    end

endmodule

// File: src/gsp_mult.sv
// Gain multiplies: P and D terms, and the I term split in two partial products.
module gsp_mult
    import gsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_BITS    = 32
)
(
    input  logic                                        clk,
    input  gsp_cfg_t                                    cfg,
    input  gsp_ctrl_t                                   ctrl,
    input  logic signed [SAMPLE_BITS:0]                 err_b,
    input  logic signed [SAMPLE_BITS+1:0]               diff_b,
    input  logic signed [SUM_BITS-1:0]                  sum_b,
    input  logic                                        use_pd_b,
    input  logic                                        use_i_b,
    input  logic                                        dead_b,
    output logic signed [GAIN_W+SAMPLE_BITS+1:0]        pp_c,
    output logic signed [GAIN_W+SAMPLE_BITS+2:0]        dp_c,
    output logic signed [GAIN_W+SUM_BITS/2+1:0]         ilo_c,
    output logic signed [GAIN_W+SUM_BITS-SUM_BITS/2:0]  ihi_c,
    output logic                                        dead_c
);

    localparam int LO  = SUM_BITS / 2;
    localparam int PW  = GAIN_W + SAMPLE_BITS + 2;
    localparam int DPW = GAIN_W + SAMPLE_BITS + 3;
    localparam int ILW = GAIN_W + LO + 2;
    localparam int IHW = GAIN_W + SUM_BITS - LO + 1;

    logic [LO-1:0]                 sum_lo;
    logic signed [SUM_BITS-LO-1:0] sum_hi;
    logic signed [PW-1:0]          pp;
    logic signed [DPW-1:0]         dp;
    logic signed [ILW-1:0]         ilo;
    logic signed [IHW-1:0]         ihi;

    always_comb
    begin
        sum_lo = sum_b[LO-1:0];
        sum_hi = $signed(sum_b[SUM_BITS-1:LO]);
        pp     = $signed({1'b0, cfg.p_gain}) * err_b;
        dp     = $signed({1'b0, cfg.d_gain}) * diff_b;
        ilo    = $signed({1'b0, cfg.i_gain}) * $signed({1'b0, sum_lo});
        ihi    = $signed({1'b0, cfg.i_gain}) * sum_hi;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_c)
        begin
            pp_c   <= use_pd_b ? pp : '0;
            dp_c   <= use_pd_b ? dp : '0;
            ilo_c  <= use_i_b ? ilo : '0;
            ihi_c  <= use_i_b ? ihi : '0;
            dead_c <= dead_b;
        end
    end

endmodule

// File: src/gsp_sat.sv
// Term summation, truncation toward zero, saturation and output clamps.
module gsp_sat
    import gsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_BITS    = 32
)
(
    input  logic                                       clk,
    input  gsp_cfg_t                                   cfg,
    input  gsp_ctrl_t                                  ctrl,
    input  logic signed [GAIN_W+SAMPLE_BITS+1:0]       pp_c,
    input  logic signed [GAIN_W+SAMPLE_BITS+2:0]       dp_c,
    input  logic signed [GAIN_W+SUM_BITS/2+1:0]        ilo_c,
    input  logic signed [GAIN_W+SUM_BITS-SUM_BITS/2:0] ihi_c,
    input  logic                                       dead_c,
    output logic [DRIVE_W-1:0]                         drive_o,
    output logic                                       dead_o
);

    localparam int LO = SUM_BITS / 2;
    localparam int MW = (SUM_BITS > SAMPLE_BITS + 2) ? SUM_BITS : SAMPLE_BITS + 2;
    localparam int AW = MW + 36;
    localparam int QW = AW - FRAC_BITS;
    localparam int VW = QSAT_W + 1;
    localparam logic [QW-1:0] QLIM = QW'(QSAT);

    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] acc_reg;
    logic                 dead_d_reg;
    logic [AW-1:0]        acc_neg;
    logic [AW-1:0]        acc_mag;
    logic [QW-1:0]        q_w;
    logic [QSAT_W-1:0]    q;
    logic signed [VW-1:0] v_abs;
    logic signed [VW-1:0] v_raw;
    logic signed [VW-1:0] v_hi;
    logic signed [VW-1:0] lim_max;
    logic signed [VW-1:0] lim_min;
    logic signed [VW-1:0] v_clamped;

    always_comb
    begin
        acc = AW'(pp_c) + AW'(dp_c) + (AW'(ihi_c) <<< (LO + 1)) + (AW'(ilo_c) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_d)
        begin
            acc_reg    <= acc;
            dead_d_reg <= dead_c;
        end
    end

    always_comb
    begin
        acc_neg = -acc_reg;
        acc_mag = acc_reg[AW-1] ? acc_neg : acc_reg;
        q_w     = acc_mag[AW-1:FRAC_BITS];
        q       = (q_w > QLIM) ? QLIM[QSAT_W-1:0] : q_w[QSAT_W-1:0];
        v_abs   = $signed({1'b0, q});
        v_raw   = acc_reg[AW-1] ? -v_abs : v_abs;
        lim_max = VW'($signed(cfg.out_max));
        lim_min = VW'($signed(cfg.out_min));
        // max clamp first, min clamp last so that min wins on crossed limits
        v_hi      = (v_raw > lim_max) ? lim_max : v_raw;
        v_clamped = (v_hi < lim_min) ? lim_min : v_hi;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_o)
        begin
            drive_o <= v_clamped[DRIVE_W-1:0];
            dead_o  <= dead_d_reg;
        end
    end

endmodule

// File: src/gsp_chk.sv
// Port-level checker for the gain scheduled PID step, bound to the top level.
module gsp_chk
    import gsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [DRIVE_W-1:0]                 m_axis_tdata,
    input logic [0:0]                         m_axis_tuser
);

    logic       s_acc;
    logic       m_acc;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    always_comb
    begin
        s_acc         = s_axis_tvalid && s_axis_tready;
        m_acc         = m_axis_tvalid && m_axis_tready;
        inflight_next = inflight_reg + 3'(s_acc) - 3'(m_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input word changed while stalled");

    // empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // no invented words, no more than five in flight
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid |-> inflight_reg != 3'd0) && inflight_reg <= 3'd5)
        else $error("word count out of range");

    // fixed latency without backpressure
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
            |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind gain_scheduled_pid_step gsp_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gsp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
